// ===== hdl/fresnel_reflectance_unit_assert.svh =====
// Assertion macros shared by the fresnel reflectance unit checkers.
// Depends on signals named clock and reset in the scope of use.
`ifndef FRESNEL_REFLECTANCE_UNIT_ASSERT_SVH
`define FRESNEL_REFLECTANCE_UNIT_ASSERT_SVH

// Checked while out of reset.
`define FRU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fresnel_reflectance_unit check failed");

// Checked at every edge, reset included.
`define FRU_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("fresnel_reflectance_unit reset check failed");

`endif

// ===== hdl/fru_pkg.sv =====
// Shared constants, widths and types of the fresnel reflectance unit.
// No dependencies.
package fru_pkg;

   localparam int VECTOR_FRAC_BITS = 14;
   localparam int RESULT_FRAC_BITS = 15;
   localparam int INT_FRAC         = 30;
   localparam int ETA_FRAC         = 12;

   localparam int VEC_W  = 16;
   localparam int IOR_W  = 14;
   localparam int RES_W  = 16;

   localparam int PROD_W = 2 * VEC_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int MAG_W  = (2 * VECTOR_FRAC_BITS + 1 > DOT_W) ?
                           2 * VECTOR_FRAC_BITS + 1 : DOT_W;
   localparam int SH_R   = (2 * VECTOR_FRAC_BITS >= INT_FRAC) ?
                           2 * VECTOR_FRAC_BITS - INT_FRAC : 0;
   localparam int SH_L   = (2 * VECTOR_FRAC_BITS < INT_FRAC) ?
                           INT_FRAC - 2 * VECTOR_FRAC_BITS : 0;
   localparam int CSH_W  = MAG_W + SH_L;

   localparam int COS_W      = INT_FRAC + 1;
   localparam int RAD_W      = 2 * INT_FRAC + 2;
   localparam int SQ_STEPS   = RAD_W / 2;
   localparam int SQ_REM_W   = INT_FRAC + 5;
   localparam int SINT_W     = INT_FRAC;
   localparam int SIN_NUM_W  = COS_W + IOR_W;
   localparam int ETA_PROD_W = IOR_W + COS_W;
   localparam int TERM_W     = ETA_PROD_W - ETA_FRAC;
   localparam int DEN_W      = TERM_W + 1;
   localparam int RATIO_W    = INT_FRAC + 1;
   localparam int SQR_W      = 2 * RATIO_W;
   localparam int KR_W       = SQR_W;
   localparam int RND_W      = KR_W + 1;
   localparam int RND_SH     = 2 * INT_FRAC - RESULT_FRAC_BITS;

   localparam logic [MAG_W-1:0] CLAMP_LIM = MAG_W'(1) << (2 * VECTOR_FRAC_BITS);
   localparam logic [RAD_W-1:0] ONE60     = RAD_W'(1) << (2 * INT_FRAC);
   localparam logic [IOR_W-1:0] ETA_ONE   = IOR_W'(1) << ETA_FRAC;
   localparam logic [RND_W-1:0] RND_HALF  = RND_W'(1) << (RND_SH - 1);
   localparam logic [RES_W-1:0] RES_MAX   = '1;
   localparam logic [RES_W-1:0] FORCE_VAL = (RESULT_FRAC_BITS >= RES_W) ? RES_MAX :
                                            RES_W'(64'd1 << RESULT_FRAC_BITS);

   typedef struct packed {
      logic signed [VEC_W-1:0] dir_x;
      logic signed [VEC_W-1:0] dir_y;
      logic signed [VEC_W-1:0] dir_z;
      logic signed [VEC_W-1:0] normal_x;
      logic signed [VEC_W-1:0] normal_y;
      logic signed [VEC_W-1:0] normal_z;
      logic [IOR_W-1:0]        ior;
   } fru_req_type;

   // Travels beside the arithmetic up to the ratio divider, which carries only the forced bit.
   typedef struct packed {
      logic [COS_W-1:0] c;
      logic [IOR_W-1:0] ei;
      logic [IOR_W-1:0] et;
      logic             forced;
   } fru_side_type;

endpackage

// ===== hdl/fru_if.sv =====
// Request and response channel interfaces of the fresnel reflectance unit.
// Depends on fru_pkg.
interface fru_req_if import fru_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] dir_x;
   logic signed [VEC_W-1:0] dir_y;
   logic signed [VEC_W-1:0] dir_z;
   logic signed [VEC_W-1:0] normal_x;
   logic signed [VEC_W-1:0] normal_y;
   logic signed [VEC_W-1:0] normal_z;
   logic [IOR_W-1:0]        index_of_refraction;

   modport source (output valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
                   index_of_refraction, input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
                   index_of_refraction, output ready);
endinterface

interface fru_rsp_if import fru_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] reflectance;
   logic             total_internal;

   modport source (output valid, reflectance, total_internal, input ready);
   modport sink   (input valid, reflectance, total_internal, output ready);
endinterface

// ===== hdl/fru_front.sv =====
// Front stages: dot product, clamp to Q30 cosine, index swap, 1 - c^2.
// Depends on fru_pkg.
module fru_front import fru_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_vld,
   input  fru_req_type      in_req,
   output logic             out_vld,
   output logic [RAD_W-1:0] out_rad,
   output fru_side_type     out_side
);

   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic [IOR_W-1:0]         ior_ff;
   logic signed [DOT_W-1:0]  dot;
   logic [MAG_W-1:0]         mag, mag_c;
   logic                     leaving;
   fru_side_type             side2_in, side2_ff, side3_ff, side4_ff;
   logic [2*COS_W-1:0]       cc_ff;
   logic [RAD_W-1:0]         rad_ff;

   always_comb begin
      dot = DOT_W'(px_ff) + DOT_W'(py_ff) + DOT_W'(pz_ff);
      leaving = !dot[DOT_W-1] && (dot != '0);
      mag = dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
      mag_c = (mag > CLAMP_LIM) ? CLAMP_LIM : mag;
      side2_in.c = COS_W'((CSH_W'(mag_c) >> SH_R) << SH_L);
      side2_in.ei = leaving ? ior_ff : ETA_ONE;
      side2_in.et = leaving ? ETA_ONE : ior_ff;
      side2_in.forced = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff    <= in_req.dir_x * in_req.normal_x;
         py_ff    <= in_req.dir_y * in_req.normal_y;
         pz_ff    <= in_req.dir_z * in_req.normal_z;
         ior_ff   <= in_req.ior;
         side2_ff <= side2_in;
         cc_ff    <= side2_ff.c * side2_ff.c;
         side3_ff <= side2_ff;
         rad_ff   <= ONE60 - RAD_W'(cc_ff);
         side4_ff <= side3_ff;
      end
   end

   assign out_vld  = v4_ff;
   assign out_rad  = rad_ff;
   assign out_side = side4_ff;

endmodule

// ===== hdl/fru_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Depends on fru_pkg.
module fru_sqrt import fru_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_vld,
   input  logic [RAD_W-1:0] in_rad,
   input  fru_side_type     in_side,
   output logic             out_vld,
   output logic [COS_W-1:0] out_root,
   output fru_side_type     out_side
);

   logic                vld_ff  [SQ_STEPS];
   logic [SQ_REM_W-1:0] rem_ff  [SQ_STEPS];
   logic [COS_W-1:0]    root_ff [SQ_STEPS];
   logic [RAD_W-1:0]    rad_ff  [SQ_STEPS];
   fru_side_type        side_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic                vld_p;
      logic [SQ_REM_W-1:0] rem_p, sh, trial, rem_in;
      logic [COS_W-1:0]    root_p, root_in;
      logic [RAD_W-1:0]    rad_p;
      fru_side_type        side_p;

      if (k == 0) begin : g_first
         assign vld_p  = in_vld;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = in_rad;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         sh    = {rem_p[SQ_REM_W-3:0], rad_p[RAD_W-1 -: 2]};
         trial = SQ_REM_W'({root_p, 2'b01});
         if (sh >= trial) begin
            rem_in  = sh - trial;
            root_in = {root_p[COS_W-2:0], 1'b1};
         end else begin
            rem_in  = sh;
            root_in = {root_p[COS_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_p << 2;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_vld  = vld_ff[SQ_STEPS-1];
   assign out_root = root_ff[SQ_STEPS-1];
   assign out_side = side_ff[SQ_STEPS-1];

endmodule

// ===== hdl/fru_sint_div.sv =====
// Pipelined divider for the transmitted sine, sin_i * ei / et, with the
// total internal reflection test at its entry. Depends on fru_pkg.
module fru_sint_div import fru_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_vld,
   input  logic [SIN_NUM_W-1:0] in_num,
   input  fru_side_type         in_side,
   output logic                 out_vld,
   output logic [SINT_W-1:0]    out_sint,
   output fru_side_type         out_side
);

   logic              vld_ff  [SINT_W];
   logic [IOR_W-1:0]  rem_ff  [SINT_W];
   logic [SINT_W-1:0] bits_ff [SINT_W];
   logic [SINT_W-1:0] q_ff    [SINT_W];
   fru_side_type      side_ff [SINT_W];
   fru_side_type      entry_side;

   // quotient reaches 1.0 exactly when the upper numerator bits reach et
   always_comb begin
      entry_side = in_side;
      entry_side.forced = in_side.forced ||
                          (in_num[SIN_NUM_W-1:SINT_W] >= {1'b0, in_side.et});
   end

   for (genvar k = 0; k < SINT_W; k++) begin : g_step
      logic              vld_p;
      logic [IOR_W-1:0]  rem_p, rem_in;
      logic [IOR_W:0]    sh;
      logic [SINT_W-1:0] bits_p, q_p, q_in;
      fru_side_type      side_p;

      if (k == 0) begin : g_first
         assign vld_p  = in_vld;
         assign rem_p  = in_num[SINT_W +: IOR_W];
         assign bits_p = in_num[SINT_W-1:0];
         assign q_p    = '0;
         assign side_p = entry_side;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign bits_p = bits_ff[k-1];
         assign q_p    = q_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      always_comb begin
         sh = {rem_p, bits_p[SINT_W-1]};
         if (sh >= {1'b0, side_p.et}) begin
            rem_in = IOR_W'(sh - {1'b0, side_p.et});
            q_in   = {q_p[SINT_W-2:0], 1'b1};
         end else begin
            rem_in = sh[IOR_W-1:0];
            q_in   = {q_p[SINT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            bits_ff[k] <= bits_p << 1;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_vld  = vld_ff[SINT_W-1];
   assign out_sint = q_ff[SINT_W-1];
   assign out_side = side_ff[SINT_W-1];

endmodule

// ===== hdl/fru_ratio_div.sv =====
// Two-lane pipelined divider for the s and p amplitude ratios,
// |num| * 2^30 / den, one quotient bit per stage. Depends on fru_pkg.
module fru_ratio_div import fru_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_vld,
   input  logic               in_forced,
   input  logic [TERM_W-1:0]  in_diff [2],
   input  logic [DEN_W-1:0]   in_den  [2],
   output logic               out_vld,
   output logic               out_forced,
   output logic [RATIO_W-1:0] out_ratio [2]
);

   logic               vld_ff    [RATIO_W];
   logic               forced_ff [RATIO_W];
   logic [DEN_W-1:0]   rem_ff    [RATIO_W][2];
   logic [DEN_W-1:0]   den_ff    [RATIO_W][2];
   logic [RATIO_W-1:0] bits_ff   [RATIO_W][2];
   logic [RATIO_W-1:0] q_ff      [RATIO_W][2];

   for (genvar k = 0; k < RATIO_W; k++) begin : g_step
      logic vld_p, forced_p;

      if (k == 0) begin : g_first
         assign vld_p    = in_vld;
         assign forced_p = in_forced;
      end else begin : g_next
         assign vld_p    = vld_ff[k-1];
         assign forced_p = forced_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            forced_ff[k] <= forced_p;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DEN_W-1:0]   rem_p, den_p, rem_in;
         logic [DEN_W:0]     sh;
         logic [RATIO_W-1:0] bits_p, q_p, q_in;

         if (k == 0) begin : g_first
            // numerator is diff << 30: the top part starts the remainder
            assign rem_p  = DEN_W'(in_diff[l] >> 1);
            assign bits_p = {in_diff[l][0], {(RATIO_W-1){1'b0}}};
            assign den_p  = in_den[l];
            assign q_p    = '0;
         end else begin : g_next
            assign rem_p  = rem_ff[k-1][l];
            assign bits_p = bits_ff[k-1][l];
            assign den_p  = den_ff[k-1][l];
            assign q_p    = q_ff[k-1][l];
         end

         always_comb begin
            sh = {rem_p, bits_p[RATIO_W-1]};
            if (sh >= {1'b0, den_p}) begin
               rem_in = DEN_W'(sh - {1'b0, den_p});
               q_in   = {q_p[RATIO_W-2:0], 1'b1};
            end else begin
               rem_in = sh[DEN_W-1:0];
               q_in   = {q_p[RATIO_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][l]  <= rem_in;
               bits_ff[k][l] <= bits_p << 1;
               den_ff[k][l]  <= den_p;
               q_ff[k][l]    <= q_in;
            end
         end
      end
   end

   assign out_vld      = vld_ff[RATIO_W-1];
   assign out_forced   = forced_ff[RATIO_W-1];
   assign out_ratio[0] = q_ff[RATIO_W-1][0];
   assign out_ratio[1] = q_ff[RATIO_W-1][1];

endmodule

// ===== hdl/fresnel_reflectance_unit.sv =====
// Unpolarized Fresnel reflectance unit, top level.
// Depends on fru_pkg, fru_if, fru_front, fru_sqrt, fru_sint_div, fru_ratio_div.
//
// Usage:
//  - req_chan carries one ray direction, one surface normal (Q1.14) and an
//    index of refraction (Q2.12) per transaction; rsp_chan returns the
//    reflectance (Q1.15) and the total_internal flag, one per request, in order.
//  - Fully pipelined: a new request is taken every cycle while rsp_chan does not
//    stall. The pipe is 135 register stages deep. The depth is set by the two
//    bit-serial square roots (31 stages each), the sine divider (30) and the
//    ratio divider (31), plus the multiply and add stages.
//  - When rsp_chan stalls, the whole pipeline holds and req_chan.ready drops;
//    an empty output register keeps ready high.
//  - Synchronous reset clears all valid bits; data registers are not reset.
//    No configuration is stored, so no configuration or warm-up is needed.
//  - Total internal reflection, a zero index on entry or a zero denominator
//    give reflectance 1.0 with total_internal set.
module fresnel_reflectance_unit import fru_pkg::*; (
   input logic       clock,
   input logic       reset,
   fru_req_if.sink   req_chan,
   fru_rsp_if.source rsp_chan
);

   logic                 adv;
   fru_req_type          req_data;

   logic                 f_vld;
   logic [RAD_W-1:0]     f_rad;
   fru_side_type         f_side;

   logic                 s1_vld;
   logic [COS_W-1:0]     s1_root;
   fru_side_type         s1_side;

   logic                 m1_vld_ff;
   logic [SIN_NUM_W-1:0] m1_num_ff;
   fru_side_type         m1_side_ff, m1_side_in;

   logic                 d_vld;
   logic [SINT_W-1:0]    d_sint;
   fru_side_type         d_side;

   logic                 m2_vld_ff, m3_vld_ff;
   logic [2*SINT_W-1:0]  m2_sq_ff;
   logic [RAD_W-1:0]     m3_rad_ff;
   fru_side_type         m2_side_ff, m3_side_ff;

   logic                 s2_vld;
   logic [COS_W-1:0]     s2_root;
   fru_side_type         s2_side;

   logic                 m4_vld_ff, m4_forced_ff;
   logic [TERM_W-1:0]    a_ff, b_ff, p_ff, q_ff;

   logic                 m5_vld_ff, m5_forced_ff, m5_forced_in;
   logic [TERM_W-1:0]    diff_ff [2];
   logic [DEN_W-1:0]     den_ff  [2];
   logic [DEN_W-1:0]     den_s, den_p;

   logic                 r_vld, r_forced;
   logic [RATIO_W-1:0]   r_ratio [2];

   logic                 m6_vld_ff, m6_forced_ff;
   logic [SQR_W-1:0]     sq_s_ff, sq_p_ff;

   logic                 m7_vld_ff, m7_forced_ff;
   logic [KR_W-1:0]      kr_ff;
   logic [RND_W-1:0]     rnd;
   logic [RES_W-1:0]     res_in;

   logic                 rsp_vld_ff, rsp_ti_ff;
   logic [RES_W-1:0]     rsp_res_ff;

   // one enable for the whole pipe: it moves unless the output is held
   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   assign req_data.dir_x    = req_chan.dir_x;
   assign req_data.dir_y    = req_chan.dir_y;
   assign req_data.dir_z    = req_chan.dir_z;
   assign req_data.normal_x = req_chan.normal_x;
   assign req_data.normal_y = req_chan.normal_y;
   assign req_data.normal_z = req_chan.normal_z;
   assign req_data.ior      = req_chan.index_of_refraction;

   fru_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_chan.valid),
      .in_req   (req_data),
      .out_vld  (f_vld),
      .out_rad  (f_rad),
      .out_side (f_side)
   );

   fru_sqrt u_sqrt_sin (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (f_vld),
      .in_rad   (f_rad),
      .in_side  (f_side),
      .out_vld  (s1_vld),
      .out_root (s1_root),
      .out_side (s1_side)
   );

   always_comb begin
      m1_side_in = s1_side;
      m1_side_in.forced = s1_side.forced || (s1_side.et == '0);
   end

   fru_sint_div u_sint_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (m1_vld_ff),
      .in_num   (m1_num_ff),
      .in_side  (m1_side_ff),
      .out_vld  (d_vld),
      .out_sint (d_sint),
      .out_side (d_side)
   );

   fru_sqrt u_sqrt_cos (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (m3_vld_ff),
      .in_rad   (m3_rad_ff),
      .in_side  (m3_side_ff),
      .out_vld  (s2_vld),
      .out_root (s2_root),
      .out_side (s2_side)
   );

   always_comb begin
      den_s = DEN_W'(a_ff) + DEN_W'(b_ff);
      den_p = DEN_W'(p_ff) + DEN_W'(q_ff);
      m5_forced_in = m4_forced_ff || (den_s == '0) || (den_p == '0);
   end

   fru_ratio_div u_ratio_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_vld     (m5_vld_ff),
      .in_forced  (m5_forced_ff),
      .in_diff    (diff_ff),
      .in_den     (den_ff),
      .out_vld    (r_vld),
      .out_forced (r_forced),
      .out_ratio  (r_ratio)
   );

   always_comb begin
      rnd = (RND_W'(kr_ff) + RND_HALF) >> RND_SH;
      if (m7_forced_ff) begin
         res_in = FORCE_VAL;
      end else if (rnd > RND_W'(RES_MAX)) begin
         res_in = RES_MAX;
      end else begin
         res_in = rnd[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         m4_vld_ff  <= 1'b0;
         m5_vld_ff  <= 1'b0;
         m6_vld_ff  <= 1'b0;
         m7_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff  <= s1_vld;
         m2_vld_ff  <= d_vld;
         m3_vld_ff  <= m2_vld_ff;
         m4_vld_ff  <= s2_vld;
         m5_vld_ff  <= m4_vld_ff;
         m6_vld_ff  <= r_vld;
         m7_vld_ff  <= m6_vld_ff;
         rsp_vld_ff <= m7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_num_ff    <= SIN_NUM_W'(s1_root) * SIN_NUM_W'(s1_side.ei);
         m1_side_ff   <= m1_side_in;
         m2_sq_ff     <= d_sint * d_sint;
         m2_side_ff   <= d_side;
         m3_rad_ff    <= ONE60 - RAD_W'(m2_sq_ff);
         m3_side_ff   <= m2_side_ff;
         a_ff         <= TERM_W'((ETA_PROD_W'(s2_side.et) * ETA_PROD_W'(s2_side.c))
                                 >> ETA_FRAC);
         b_ff         <= TERM_W'((ETA_PROD_W'(s2_side.ei) * ETA_PROD_W'(s2_root))
                                 >> ETA_FRAC);
         p_ff         <= TERM_W'((ETA_PROD_W'(s2_side.ei) * ETA_PROD_W'(s2_side.c))
                                 >> ETA_FRAC);
         q_ff         <= TERM_W'((ETA_PROD_W'(s2_side.et) * ETA_PROD_W'(s2_root))
                                 >> ETA_FRAC);
         m4_forced_ff <= s2_side.forced;
         diff_ff[0]   <= (a_ff > b_ff) ? a_ff - b_ff : b_ff - a_ff;
         diff_ff[1]   <= (p_ff > q_ff) ? p_ff - q_ff : q_ff - p_ff;
         den_ff[0]    <= den_s;
         den_ff[1]    <= den_p;
         m5_forced_ff <= m5_forced_in;
         sq_s_ff      <= r_ratio[0] * r_ratio[0];
         sq_p_ff      <= r_ratio[1] * r_ratio[1];
         m6_forced_ff <= r_forced;
         kr_ff        <= KR_W'(((SQR_W + 1)'(sq_s_ff) + (SQR_W + 1)'(sq_p_ff)) >> 1);
         m7_forced_ff <= m6_forced_ff;
         rsp_res_ff   <= res_in;
         rsp_ti_ff    <= m7_forced_ff;
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.reflectance    = rsp_res_ff;
   assign rsp_chan.total_internal = rsp_ti_ff;

endmodule

// ===== hdl/fru_checker.sv =====
// Port-level checks of the fresnel reflectance unit, bound to the top level.
// Depends on fru_pkg and fresnel_reflectance_unit_assert.svh.
module fru_checker import fru_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [RES_W-1:0] reflectance,
   input logic             total_internal
);

`include "fresnel_reflectance_unit_assert.svh"

   // a held response keeps its payload
   `FRU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(reflectance) && $stable(total_internal))

   // an empty output register never blocks the request side
   `FRU_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready)

   // the flag always comes with a forced one
   `FRU_ASSERT(a_forced_value, rsp_valid && total_internal |-> reflectance == FORCE_VAL)

   // reflectance never exceeds one
   `FRU_ASSERT(a_range, rsp_valid |-> reflectance <= FORCE_VAL)

   // reset flushes the pipe
   `FRU_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid)

endmodule

bind fresnel_reflectance_unit fru_checker u_fru_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .reflectance    (rsp_chan.reflectance),
   .total_internal (rsp_chan.total_internal)
);
